FILE: src/gpht_pkg.sv
// Shared types, constants and codes of the grouped-probe hash table.
package gpht_pkg;

    localparam int GROUP_COUNT_DEF = 64;
    localparam int GROUP_WIDTH     = 16;
    localparam int SLOT_BITS       = 4;
    localparam int VALUE_BITS_DEF  = 32;
    localparam int KEY_BITS        = 64;
    localparam int TAG_BITS        = 7;
    localparam int LIMIT_BITS      = 10;
    localparam int COUNT_BITS      = 11;
    localparam int RSP_VALUE_BITS  = 32;
    localparam int REQ_VALUE_BITS  = 32;
    localparam int MIX_SHIFT       = 32;

    localparam logic [63:0]           MIX_MUL        = 64'hd6e8feb86659fd93;
    localparam logic [7:0]            CTRL_EMPTY     = 8'h80;
    localparam logic [7:0]            CTRL_TOMB      = 8'hFE;
    localparam logic [LIMIT_BITS-1:0] USED_LIMIT_RST = 10'd896;

    typedef enum logic [1:0] {
        OP_UPSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_ERASE  = 2'd2,
        OP_GETINS = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_INSERTED = 2'd1,
        ST_ABSENT   = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        t_op                       opcode;
        logic [KEY_BITS-1:0]       lookup_key;
        logic [REQ_VALUE_BITS-1:0] store_value;
    } t_req;

    typedef struct packed {
        t_status                   status;
        logic [RSP_VALUE_BITS-1:0] read_value;
    } t_rsp;

    // Commands from the sequencer to the slot store
    typedef struct packed {
        logic clr;
        logic rd;
        logic ctrl_we;
        logic key_we;
        logic val_we;
    } t_mem_cmd;

endpackage

FILE: src/grouped_probe_hash_table.sv
// Grouped-probe hash table for 64-bit keys: sequencer, counters and response register.
//
// Request channel (i_req_valid / o_req_ready, payload i_req): opcode, key and
// value of one operation (upsert, lookup, erase, get-or-insert-zero).
// Response channel (o_rsp_valid / i_rsp_ready, payload o_rsp): status and the
// value held for the key after the operation. One response per request, in order.
// Configuration: i_cfg_wen writes i_cfg_wdata into the used-slot limit at once.
// One request is worked at a time. A request first has its key mixed on a
// shared 32x32 multiplier, ending with the hand-off of tag and start group (with
// a group reduction added when GROUP_COUNT is not a power of two), then, per
// probed group, a row read of the slot store and a check of its 16 slots.
// With a hit or an empty slot in the first group the walk ends at the first
// check; the response is registered and o_req_ready returns in the same cycle.
// Writes of the slot store happen in the check cycle.
// After reset a clearing pass writes every control row to empty, one row per
// cycle, while o_req_ready stays low.
// The response register holds its result while the receiver stalls; the next
// request is accepted meanwhile and waits at its check step for the register.
module grouped_probe_hash_table #(
    parameter int GROUP_COUNT = gpht_pkg::GROUP_COUNT_DEF,
    parameter int VALUE_BITS  = gpht_pkg::VALUE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_req_valid,
    output logic                              o_req_ready,
    input  gpht_pkg::t_req                    i_req,
    output logic                              o_rsp_valid,
    input  logic                              i_rsp_ready,
    output gpht_pkg::t_rsp                    o_rsp,
    input  logic                              i_cfg_wen,
    input  logic [gpht_pkg::LIMIT_BITS-1:0]   i_cfg_wdata
);

    localparam int GB = $clog2(GROUP_COUNT);
    localparam int GW = gpht_pkg::GROUP_WIDTH;
    localparam int SB = gpht_pkg::SLOT_BITS;
    localparam int CB = gpht_pkg::COUNT_BITS;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HASH  = 5'b00100,
        S_READ  = 5'b01000,
        S_CHECK = 5'b10000
    } t_state;

    t_state r_state, n_state;

    gpht_pkg::t_req  r_req;
    gpht_pkg::t_rsp  r_rsp;
    logic            r_rsp_valid;
    logic [GB-1:0]   r_clr_row;
    logic [GB-1:0]   r_group;
    logic [GB-1:0]   r_probe_n;
    logic [gpht_pkg::TAG_BITS-1:0] r_tag;
    logic [CB-1:0]   r_used;
    logic [CB-1:0]   r_live;
    logic [gpht_pkg::LIMIT_BITS-1:0] r_used_limit;

    logic                          w_accept;
    logic                          w_hash_done;
    logic [gpht_pkg::TAG_BITS-1:0] w_hash_tag;
    logic [GB-1:0]                 w_hash_group;

    gpht_pkg::t_mem_cmd w_cmd;
    logic [GB-1:0]      w_wr_row;
    logic [SB-1:0]      w_wr_slot;
    logic [7:0]         w_wr_ctrl;
    logic [VALUE_BITS-1:0] w_new_val;
    logic [GW-1:0][7:0]                    w_ctrl_row;
    logic [GW-1:0][gpht_pkg::KEY_BITS-1:0] w_key_row;
    logic [GW-1:0][VALUE_BITS-1:0]         w_val_row;

    logic [GW-1:0] w_match;
    logic [GW-1:0] w_empty;
    logic [SB-1:0] w_match_idx;
    logic [SB-1:0] w_empty_idx;
    logic          w_found;
    logic          w_has_empty;
    logic          w_last;
    logic          w_end;
    logic          w_is_ins;
    logic          w_under;
    logic          w_do_insert;
    logic          w_do_erase;
    logic          w_out_free;
    logic          w_fire;
    gpht_pkg::t_rsp w_rsp;

    assign o_req_ready = (r_state == S_IDLE);
    assign w_accept    = i_req_valid && o_req_ready;

    gpht_hash #(
        .GROUP_COUNT (GROUP_COUNT)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_key   (i_req.lookup_key),
        .o_done  (w_hash_done),
        .o_tag   (w_hash_tag),
        .o_group (w_hash_group)
    );

    // slot checks on the row read at the read step
    always_comb begin
        for (int i = 0; i < GW; i++) begin
            w_match[i] = (w_ctrl_row[i] == {1'b0, r_tag})
                      && (w_key_row[i] == r_req.lookup_key);
            w_empty[i] = (w_ctrl_row[i] == gpht_pkg::CTRL_EMPTY);
        end
        w_match_idx = '0;
        w_empty_idx = '0;
        for (int i = GW - 1; i >= 0; i--) begin
            if (w_match[i]) w_match_idx = SB'(i);
            if (w_empty[i]) w_empty_idx = SB'(i);
        end
    end

    assign w_found     = |w_match;
    assign w_has_empty = |w_empty;
    assign w_last      = (r_probe_n == GB'(GROUP_COUNT - 1));
    assign w_end       = w_found || w_has_empty || w_last;
    assign w_is_ins    = (r_req.opcode == gpht_pkg::OP_UPSERT)
                      || (r_req.opcode == gpht_pkg::OP_GETINS);
    assign w_under     = (r_used < CB'(r_used_limit));
    assign w_do_insert = !w_found && w_is_ins && w_has_empty && w_under;
    assign w_do_erase  = w_found && (r_req.opcode == gpht_pkg::OP_ERASE);
    assign w_out_free  = !r_rsp_valid || i_rsp_ready;
    assign w_fire      = (r_state == S_CHECK) && w_end && w_out_free;

    // new value for upsert, zero for get-or-insert
    assign w_new_val = (r_req.opcode == gpht_pkg::OP_UPSERT)
                     ? VALUE_BITS'(r_req.store_value) : '0;

    always_comb begin
        w_rsp.status     = gpht_pkg::ST_FULL;
        w_rsp.read_value = '0;
        if (w_found) begin
            w_rsp.status = gpht_pkg::ST_FOUND;
            case (r_req.opcode)
                gpht_pkg::OP_UPSERT: w_rsp.read_value = 32'(w_new_val);
                gpht_pkg::OP_ERASE:  w_rsp.read_value = '0;
                default:             w_rsp.read_value = 32'(w_val_row[w_match_idx]);
            endcase
        end else if (!w_is_ins) begin
            w_rsp.status = gpht_pkg::ST_ABSENT;
        end else if (w_do_insert) begin
            w_rsp.status     = gpht_pkg::ST_INSERTED;
            w_rsp.read_value = 32'(w_new_val);
        end
    end

    // store commands: clear rows after reset, read at the read step, write back at the check step
    always_comb begin
        w_cmd.clr     = (r_state == S_CLEAR);
        w_cmd.rd      = (r_state == S_READ);
        w_cmd.ctrl_we = w_fire && (w_do_erase || w_do_insert);
        w_cmd.key_we  = w_fire && w_do_insert;
        w_cmd.val_we  = w_fire && (w_do_insert
                     || (w_found && (r_req.opcode == gpht_pkg::OP_UPSERT)));
        w_wr_row      = (r_state == S_CLEAR) ? r_clr_row : r_group;
        w_wr_slot     = w_found ? w_match_idx : w_empty_idx;
        w_wr_ctrl     = w_do_insert ? {1'b0, r_tag} : gpht_pkg::CTRL_TOMB;
    end

    gpht_store #(
        .GROUP_COUNT (GROUP_COUNT),
        .VALUE_BITS  (VALUE_BITS)
    ) u_store (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_rd_row   (r_group),
        .i_wr_row   (w_wr_row),
        .i_wr_slot  (w_wr_slot),
        .i_wr_ctrl  (w_wr_ctrl),
        .i_wr_key   (r_req.lookup_key),
        .i_wr_val   (w_new_val),
        .o_ctrl_row (w_ctrl_row),
        .o_key_row  (w_key_row),
        .o_val_row  (w_val_row)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_row == GB'(GROUP_COUNT - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) n_state = S_HASH;
            end
            S_HASH: begin
                if (w_hash_done) n_state = S_READ;
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                // advance to the next group, or finish once the response slot is free
                if (!w_end) n_state = S_READ;
                else if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_row    <= '0;
            r_rsp_valid  <= 1'b0;
            r_used       <= '0;
            r_live       <= '0;
            r_used_limit <= gpht_pkg::USED_LIMIT_RST;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_row <= r_clr_row + GB'(1);
            end
            if (i_cfg_wen) begin
                r_used_limit <= i_cfg_wdata;
            end
            if (w_fire) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
            if (w_fire && w_do_insert) begin
                r_used <= r_used + CB'(1);
                r_live <= r_live + CB'(1);
            end else if (w_fire && w_do_erase) begin
                r_live <= r_live - CB'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
        if (r_state == S_HASH && w_hash_done) begin
            r_tag     <= w_hash_tag;
            r_group   <= w_hash_group;
            r_probe_n <= '0;
        end else if (r_state == S_CHECK && !w_end) begin
            r_group   <= (r_group == GB'(GROUP_COUNT - 1)) ? '0 : r_group + GB'(1);
            r_probe_n <= r_probe_n + GB'(1);
        end
        if (w_fire) begin
            r_rsp <= w_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

`ifndef SYNTHESIS
    a_live_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= r_used)
        else $error("live entries exceed used slots");

    a_rsp_from_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(r_state == S_CHECK))
        else $error("response raised outside the check step");

    a_no_read_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!w_cmd.rd && !w_cmd.ctrl_we && !o_req_ready))
        else $error("store access or request taken during clearing pass");
`endif

endmodule

FILE: src/gpht_hash.sv
// Multi-cycle key mixer: 64-bit finalizer on one 32x32 multiplier, then tag and start group.
module gpht_hash #(
    parameter int GROUP_COUNT = gpht_pkg::GROUP_COUNT_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [gpht_pkg::KEY_BITS-1:0]        i_key,
    output logic                                 o_done,
    output logic [gpht_pkg::TAG_BITS-1:0]        o_tag,
    output logic [$clog2(GROUP_COUNT)-1:0]       o_group
);

    localparam int GB        = $clog2(GROUP_COUNT);
    localparam bit IS_POW2   = (GROUP_COUNT & (GROUP_COUNT - 1)) == 0;
    localparam int MIX_STEP  = 4;
    localparam int LAST_STEP = IS_POW2 ? MIX_STEP : MIX_STEP + 8;

    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_step;
    logic [63:0] r_a;
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic [63:0] r_quot;
    logic [GB-1:0] r_rem;
    logic [gpht_pkg::TAG_BITS-1:0] r_tag;

    logic [31:0]   w_mx;
    logic [31:0]   w_my;
    logic [63:0]   w_prod;
    logic [63:0]   w_h;
    logic [GB-1:0] w_rem_next;

    // low 64 bits of a*MUL: aL*bL + ((aL*bH + aH*bL) << 32)
    always_comb begin
        case (r_step)
            4'd0:    begin w_mx = r_a[31:0];  w_my = gpht_pkg::MIX_MUL[31:0];  end
            4'd1:    begin w_mx = r_a[31:0];  w_my = gpht_pkg::MIX_MUL[63:32]; end
            default: begin w_mx = r_a[63:32]; w_my = gpht_pkg::MIX_MUL[31:0];  end
        endcase
    end

    assign w_prod = 64'(w_mx) * 64'(w_my);
    assign w_h    = r_acc ^ (r_acc >> gpht_pkg::MIX_SHIFT);

    // one byte of the quotient source per cycle, restoring reduction bit by bit
    always_comb begin
        logic [GB:0] t;
        logic [GB-1:0] rem;
        rem = r_rem;
        for (int i = 7; i >= 0; i--) begin
            t = {rem, r_quot[56 + i]};
            if (t >= (GB + 1)'(GROUP_COUNT)) begin
                t = t - (GB + 1)'(GROUP_COUNT);
            end
            rem = t[GB-1:0];
        end
        w_rem_next = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == 4'(LAST_STEP)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= {i_key[63:32], i_key[31:0] ^ i_key[63:32]};
        end
        if (r_busy) begin
            r_prod <= w_prod;
            case (r_step)
                4'd1: r_acc <= r_prod;
                4'd2, 4'd3: r_acc[63:32] <= r_acc[63:32] + r_prod[31:0];
                4'(MIX_STEP): begin
                    r_tag  <= w_h[gpht_pkg::TAG_BITS-1:0];
                    r_quot <= w_h >> gpht_pkg::TAG_BITS;
                    r_rem  <= IS_POW2 ? w_h[gpht_pkg::TAG_BITS +: GB] : '0;
                end
                default: begin
                    r_rem  <= w_rem_next;
                    r_quot <= r_quot << 8;
                end
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_tag   = r_tag;
    assign o_group = r_rem;

endmodule

FILE: src/gpht_store.sv
// Slot store: control bytes, keys and values, one group per row, registered read.
module gpht_store #(
    parameter int GROUP_COUNT = gpht_pkg::GROUP_COUNT_DEF,
    parameter int VALUE_BITS  = gpht_pkg::VALUE_BITS_DEF
) (
    input  logic                                                   i_clk,
    input  gpht_pkg::t_mem_cmd                                     i_cmd,
    input  logic [$clog2(GROUP_COUNT)-1:0]                         i_rd_row,
    input  logic [$clog2(GROUP_COUNT)-1:0]                         i_wr_row,
    input  logic [gpht_pkg::SLOT_BITS-1:0]                         i_wr_slot,
    input  logic [7:0]                                             i_wr_ctrl,
    input  logic [gpht_pkg::KEY_BITS-1:0]                          i_wr_key,
    input  logic [VALUE_BITS-1:0]                                  i_wr_val,
    output logic [gpht_pkg::GROUP_WIDTH-1:0][7:0]                  o_ctrl_row,
    output logic [gpht_pkg::GROUP_WIDTH-1:0][gpht_pkg::KEY_BITS-1:0] o_key_row,
    output logic [gpht_pkg::GROUP_WIDTH-1:0][VALUE_BITS-1:0]       o_val_row
);

    localparam int GW = gpht_pkg::GROUP_WIDTH;

    logic [GW-1:0][7:0]                  r_ctrl_mem [GROUP_COUNT];
    logic [GW-1:0][gpht_pkg::KEY_BITS-1:0] r_key_mem [GROUP_COUNT];
    logic [GW-1:0][VALUE_BITS-1:0]       r_val_mem  [GROUP_COUNT];

    logic [GW-1:0][7:0]                  r_ctrl_rd;
    logic [GW-1:0][gpht_pkg::KEY_BITS-1:0] r_key_rd;
    logic [GW-1:0][VALUE_BITS-1:0]       r_val_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_ctrl_mem[i_wr_row] <= {GW{gpht_pkg::CTRL_EMPTY}};
        end else if (i_cmd.ctrl_we) begin
            r_ctrl_mem[i_wr_row][i_wr_slot] <= i_wr_ctrl;
        end
        if (i_cmd.key_we) begin
            r_key_mem[i_wr_row][i_wr_slot] <= i_wr_key;
        end
        if (i_cmd.val_we) begin
            r_val_mem[i_wr_row][i_wr_slot] <= i_wr_val;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_ctrl_rd <= r_ctrl_mem[i_rd_row];
            r_key_rd  <= r_key_mem[i_rd_row];
            r_val_rd  <= r_val_mem[i_rd_row];
        end
    end

    assign o_ctrl_row = r_ctrl_rd;
    assign o_key_row  = r_key_rd;
    assign o_val_row  = r_val_rd;

endmodule

FILE: tb/grouped_probe_hash_table_tb.sv
// Self-checking testbench for the grouped-probe hash table.
`timescale 1ns / 100ps

module grouped_probe_hash_table_tb;

    localparam int GROUPS     = gpht_pkg::GROUP_COUNT_DEF;
    localparam int SLOTS      = GROUPS * gpht_pkg::GROUP_WIDTH;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_WAIT = 16;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_req_valid;
    logic                            o_req_ready;
    gpht_pkg::t_req                  i_req;
    logic                            o_rsp_valid;
    logic                            i_rsp_ready;
    gpht_pkg::t_rsp                  o_rsp;
    logic                            i_cfg_wen;
    logic [gpht_pkg::LIMIT_BITS-1:0] i_cfg_wdata;

    grouped_probe_hash_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Shadow copy of the table, kept in step with every accepted request
    logic [7:0]                      shadow_ctrl [SLOTS];
    logic [gpht_pkg::KEY_BITS-1:0]   shadow_key  [SLOTS];
    logic [31:0]                     shadow_val  [SLOTS];
    int unsigned                     shadow_used;
    logic [gpht_pkg::LIMIT_BITS-1:0] shadow_limit;

    gpht_pkg::t_rsp                  pending_rsp_q[$];
    logic [gpht_pkg::KEY_BITS-1:0]   key_pool[$];
    int                    fail_count;
    int                    hold_cycles;  // receiver hold-off requested by a test
    bit                    no_idle;      // suppress random gaps on both sides
    int                    idle_count;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Key finalizer: xor-shift, multiply, xor-shift
    function automatic logic [63:0] mix_key(input logic [63:0] k);
        logic [63:0] h;
        h = k ^ (k >> gpht_pkg::MIX_SHIFT);
        h = h * gpht_pkg::MIX_MUL;
        return h ^ (h >> gpht_pkg::MIX_SHIFT);
    endfunction

    // Walk the groups from the start group; return the hit slot or -1.
    // free_slot gets the first empty slot of the group that ended the walk.
    function automatic int find_slot(input logic [63:0] key, output int free_slot);
        logic [63:0] h;
        logic [6:0]  tag;
        int          grp;
        int          base;
        h         = mix_key(key);
        tag       = h[6:0];
        grp       = int'((h >> 7) % GROUPS);
        free_slot = -1;
        for (int n = 0; n < GROUPS; n++) begin
            base = grp * gpht_pkg::GROUP_WIDTH;
            for (int o = 0; o < gpht_pkg::GROUP_WIDTH; o++)
                if (shadow_ctrl[base+o] == {1'b0, tag} && shadow_key[base+o] == key)
                    return base + o;
            for (int o = 0; o < gpht_pkg::GROUP_WIDTH; o++)
                if (shadow_ctrl[base+o] == gpht_pkg::CTRL_EMPTY) begin
                    free_slot = base + o;
                    return -1;
                end
            grp = (grp + 1) % GROUPS;
        end
        return -1;
    endfunction

    // Apply one request to the shadow table and return its response
    function automatic gpht_pkg::t_rsp apply_request(input gpht_pkg::t_req req);
        gpht_pkg::t_rsp rsp;
        int    hit;
        int    free_slot;
        logic [63:0] h;
        rsp.read_value = '0;
        hit = find_slot(req.lookup_key, free_slot);
        if (hit >= 0) begin
            rsp.status = gpht_pkg::ST_FOUND;
            case (req.opcode)
                gpht_pkg::OP_UPSERT: begin
                    shadow_val[hit] = req.store_value;
                    rsp.read_value  = req.store_value;
                end
                gpht_pkg::OP_ERASE: shadow_ctrl[hit] = gpht_pkg::CTRL_TOMB;
                default:  rsp.read_value = shadow_val[hit];
            endcase
        end else if (req.opcode == gpht_pkg::OP_LOOKUP
                     || req.opcode == gpht_pkg::OP_ERASE) begin
            rsp.status = gpht_pkg::ST_ABSENT;
        end else if (free_slot < 0 || shadow_used + 1 > shadow_limit) begin
            rsp.status = gpht_pkg::ST_FULL;
        end else begin
            h = mix_key(req.lookup_key);
            shadow_ctrl[free_slot] = {1'b0, h[6:0]};
            shadow_key[free_slot]  = req.lookup_key;
            shadow_val[free_slot]  = (req.opcode == gpht_pkg::OP_UPSERT)
                                   ? req.store_value : '0;
            shadow_used++;
            rsp.status     = gpht_pkg::ST_INSERTED;
            rsp.read_value = shadow_val[free_slot];
        end
        return rsp;
    endfunction

    // Pick a gap: mostly none, sometimes short, a few long
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    // Offer one request; return at the edge where it is accepted
    task automatic send_request(input gpht_pkg::t_op op, input logic [63:0] key,
                                input logic [31:0] value);
        int gap;
        gpht_pkg::t_req req;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_req_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req.opcode      = op;
        req.lookup_key  = key;
        req.store_value = value;
        i_req       = req;
        i_req_valid = 1'b1;
        do @(posedge i_clk); while (!o_req_ready);
        pending_rsp_q.push_back(apply_request(req));
    endtask

    // Hold off until every response is back and the block has gone quiet
    task automatic wait_drained();
        @(negedge i_clk);
        i_req_valid = 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [gpht_pkg::LIMIT_BITS-1:0] limit);
        wait_drained();
        @(negedge i_clk);
        i_cfg_wen   = 1'b1;
        i_cfg_wdata = limit;
        @(negedge i_clk);
        i_cfg_wen    = 1'b0;
        shadow_limit = limit;
    endtask

    function automatic logic [63:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    // Extremes of key and value, every opcode, erase leaving a tombstone
    task automatic test_directed();
        logic [63:0] k_lo;
        logic [63:0] k_hi;
        k_lo = 64'h0;
        k_hi = '1;
        send_request(gpht_pkg::OP_LOOKUP, k_lo, 32'h0);
        send_request(gpht_pkg::OP_ERASE,  k_hi, 32'h0);
        send_request(gpht_pkg::OP_UPSERT, k_lo, 32'hFFFF_FFFF);
        send_request(gpht_pkg::OP_UPSERT, k_hi, 32'h0);
        send_request(gpht_pkg::OP_LOOKUP, k_lo, 32'h1234_5678);
        send_request(gpht_pkg::OP_UPSERT, k_lo, 32'h0);
        send_request(gpht_pkg::OP_GETINS, k_hi, 32'hFFFF_FFFF);
        send_request(gpht_pkg::OP_GETINS, 64'h5555_5555_AAAA_AAAA, 32'hFFFF_FFFF);
        send_request(gpht_pkg::OP_LOOKUP, 64'h5555_5555_AAAA_AAAA, 32'h0);
        send_request(gpht_pkg::OP_ERASE,  k_hi, 32'h0);
        send_request(gpht_pkg::OP_LOOKUP, k_hi, 32'h0);
        send_request(gpht_pkg::OP_ERASE,  k_hi, 32'h0);
        send_request(gpht_pkg::OP_UPSERT, k_hi, 32'hA5A5_5A5A);
        send_request(gpht_pkg::OP_LOOKUP, k_hi, 32'h0);
        send_request(gpht_pkg::OP_GETINS, k_lo, 32'h0);
        key_pool.push_back(k_lo);
        key_pool.push_back(k_hi);
    endtask

    // Drive the used limit to its edges and check inserts report full
    task automatic test_used_limit();
        write_limit(gpht_pkg::LIMIT_BITS'(shadow_used + 2));
        repeat (5) send_request(gpht_pkg::OP_UPSERT, rand_key(), $urandom());
        send_request(gpht_pkg::OP_LOOKUP, key_pool[0], 32'h0);
        write_limit('0);
        send_request(gpht_pkg::OP_GETINS, rand_key(), 32'h0);
        send_request(gpht_pkg::OP_UPSERT, key_pool[1], $urandom());
        write_limit(10'd1);
        send_request(gpht_pkg::OP_UPSERT, rand_key(), $urandom());
        send_request(gpht_pkg::OP_GETINS, key_pool[0], 32'h0);
        write_limit('1);
    endtask

    // Random mix over a small key pool so hits, erases and re-inserts happen
    task automatic test_random(input int count);
        logic [63:0]   key;
        gpht_pkg::t_op op;
        for (int i = 0; i < count; i++) begin
            no_idle = (i % 200) >= 150;
            if (key_pool.size() < 40 || $urandom_range(0, 99) < 30) begin
                key = rand_key();
                if (key_pool.size() < 64) key_pool.push_back(key);
            end else begin
                key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            end
            op = gpht_pkg::t_op'($urandom_range(0, 3));
            send_request(op, key, $urandom());
        end
        no_idle = 1'b0;
    endtask

    // Stall the receiver for a long stretch while requests keep coming
    task automatic test_backpressure();
        wait_drained();
        hold_cycles = 300;
        no_idle     = 1'b1;
        for (int i = 0; i < 20; i++)
            send_request(gpht_pkg::t_op'($urandom_range(0, 3)),
                         key_pool[$urandom_range(0, key_pool.size() - 1)], $urandom());
        no_idle = 1'b0;
    endtask

    // Receiver ready: random stalls, or a hold-off when a test asks
    initial begin
        int stall;
        i_rsp_ready = 1'b0;
        stall       = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_rsp_ready = 1'b0;
                hold_cycles--;
            end else if (stall > 0) begin
                i_rsp_ready = 1'b0;
                stall--;
            end else begin
                stall       = pick_gap();
                i_rsp_ready = (stall == 0);
                if (stall > 0) stall--;
            end
        end
    end

    // Compare each accepted response with the oldest expectation
    always @(posedge i_clk) begin
        gpht_pkg::t_rsp want;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (pending_rsp_q.size() == 0) begin
                report_mismatch("unexpected response", o_rsp, 0);
            end else begin
                want = pending_rsp_q.pop_front();
                if (o_rsp.status !== want.status)
                    report_mismatch("status", o_rsp.status, want.status);
                if (o_rsp.read_value !== want.read_value)
                    report_mismatch("read_value", o_rsp.read_value, want.read_value);
            end
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count > IDLE_LIMIT) begin
            $display("** grouped_probe_hash_table: FAILED **");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_req_valid  = 1'b0;
        i_req        = '0;
        i_cfg_wen    = 1'b0;
        i_cfg_wdata  = '0;
        fail_count   = 0;
        hold_cycles  = 0;
        no_idle      = 1'b0;
        idle_count   = 0;
        shadow_used  = 0;
        shadow_limit = gpht_pkg::USED_LIMIT_RST;
        for (int s = 0; s < SLOTS; s++) begin
            shadow_ctrl[s] = gpht_pkg::CTRL_EMPTY;
            shadow_key[s]  = '0;
            shadow_val[s]  = '0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_used_limit();
        test_random(400);
        test_backpressure();
        test_random(400);
        write_limit(10'd1);
        test_random(20);

        wait_drained();
        if (fail_count == 0)
            $display("** grouped_probe_hash_table: PASSED **");
        else
            $display("** grouped_probe_hash_table: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
src/gpht_pkg.sv
src/gpht_hash.sv
src/gpht_store.sv
src/grouped_probe_hash_table.sv
tb/grouped_probe_hash_table_tb.sv
